FILE: hw/rtl/rdfd_pkg.sv
// ----------------------------------------------------------------------------
// Remote drive frame decoder package
// Shared constants, the result word type and the steering-to-duty map.
// ----------------------------------------------------------------------------
package rdfd_pkg;

    localparam int TEXT_DEPTH_DEF = 16;

    localparam logic [7:0] STEER_SLOT = 8'd35;
    localparam logic [7:0] MODE_RUN   = 8'h52;

    // Breakpoints of the steering map.
    localparam logic [7:0] STEER_LO_END   = 8'd115;
    localparam logic [7:0] STEER_HI_START = 8'd142;
    localparam logic [7:0] DUTY_MID       = 8'd191;

    // Division by 114, 115 and 100 is done by multiplication with a scaled
    // reciprocal and a shift of 22. For numerators below 2^15 the result is
    // exact, and the numerator's own constant factor is folded into the
    // reciprocal so that each branch needs a single multiplier.
    localparam int RECIP_SHIFT = 22;
    localparam logic [31:0] REC_114 = 32'd36793;
    localparam logic [31:0] REC_115 = 32'd36473;
    localparam logic [31:0] REC_100 = 32'd41944;

    localparam logic [31:0] L_LO_MUL  = 32'(191 * REC_114);
    localparam logic [31:0] L_HI_MUL  = 32'(64 * REC_114);
    localparam logic [31:0] L_HI_ADD  = 32'(12654 * REC_114);
    localparam logic [31:0] R_LO_MUL  = 32'(64 * REC_115);
    localparam logic [31:0] R_LO_BASE = 32'(29210 * REC_115);
    localparam logic [31:0] R_HI_MUL  = 32'(167 * REC_100);
    localparam logic [31:0] R_HI_BASE = 32'(42800 * REC_100);

    typedef struct packed {
        logic       running;
        logic       slot_rejected;
        logic       frame_accepted;
        logic [7:0] right_duty;
        logic [7:0] left_duty;
    } rdfd_result_t;

    function automatic logic [7:0] duty_left(input logic [7:0] d);
        logic [31:0] p;
        logic [7:0]  q;
        p = 32'd0;
        q = DUTY_MID;
        if (d < STEER_LO_END)
        begin
            p = 32'(d) * L_LO_MUL;
            q = p[RECIP_SHIFT +: 8];
        end
        else if (d >= STEER_HI_START)
        begin
            p = 32'(d) * L_HI_MUL + L_HI_ADD;
            q = p[RECIP_SHIFT +: 8];
        end
        return q;
    endfunction

    function automatic logic [7:0] duty_right(input logic [7:0] d);
        logic [31:0] p;
        logic [7:0]  q;
        p = 32'd0;
        q = DUTY_MID;
        if (d < STEER_LO_END)
        begin
            p = R_LO_BASE - 32'(d) * R_LO_MUL;
            q = p[RECIP_SHIFT +: 8];
        end
        else if (d >= STEER_HI_START)
        begin
            p = R_HI_BASE - 32'(d) * R_HI_MUL;
            q = p[RECIP_SHIFT +: 8];
        end
        return q;
    endfunction

endpackage

FILE: hw/rtl/remote_drive_frame_decoder_unit.sv
// ----------------------------------------------------------------------------
// Remote drive frame decoder
// Checks a sliding four-byte frame, updates steering and mode, maps duties.
// ----------------------------------------------------------------------------
// Each accepted input word's result is registered in the result register
// (or the skid register). Throughput: one word per cycle while the skid is empty;
// the frame check and the duty map are a single pass of logic in front of them.
// A two-entry output stage (result register and skid register) keeps
// s_tready independent of m_tready.
// Reset (rst_n, asynchronous): window, steering, mode and address clear to 0.
module remote_drive_frame_decoder_unit
    import rdfd_pkg::*;
#(
    parameter int TEXT_DEPTH = TEXT_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,     // station_address
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,      // left_duty [7:0], right_duty [15:8]
    output logic [2:0]  m_tuser       // frame_accepted, slot_rejected, running
);

    logic [23:0]  window_reg;
    logic [7:0]   steer_reg;
    logic [7:0]   steer_next;
    logic [7:0]   text0_reg;
    logic [7:0]   text0_next;
    logic [7:0]   mode_reg;
    logic [7:0]   mode_next;
    logic [7:0]   station_reg;

    logic         out_valid_reg;
    rdfd_result_t out_reg;
    logic         skid_valid_reg;
    rdfd_result_t skid_reg;

    logic         in_fire;
    logic [7:0]   addr_b;
    logic [7:0]   slot_b;
    logic [7:0]   val_b;
    logic [7:0]   sum_b;
    logic         frame_ok;
    logic         slot_text;
    logic         run_next;
    rdfd_result_t result;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign in_fire   = s_tvalid && s_tready;

    assign addr_b = window_reg[23:16];
    assign slot_b = window_reg[15:8];
    assign val_b  = window_reg[7:0];
    assign sum_b  = addr_b + slot_b + val_b;

    assign frame_ok  = (s_tdata == sum_b) && (addr_b == station_reg);
    assign slot_text = slot_b < 8'(TEXT_DEPTH);

    // Only the first text entry is ever read back (as the mode character),
    // so it is the only entry held; the depth still decides which slots
    // are valid text writes.
    always_comb
    begin
        steer_next = steer_reg;
        text0_next = text0_reg;
        mode_next  = mode_reg;
        if (frame_ok && slot_b != STEER_SLOT && slot_text)
        begin
            if (slot_b == 8'd0)
            begin
                text0_next = val_b;
            end
            if (val_b == 8'd0)
            begin
                mode_next = text0_next;
            end
        end
        else if (frame_ok && slot_b == STEER_SLOT)
        begin
            steer_next = val_b;
        end
    end

    assign run_next = (mode_next == MODE_RUN);

    always_comb
    begin
        result.running        = run_next;
        result.frame_accepted = frame_ok;
        result.slot_rejected  = frame_ok && slot_b != STEER_SLOT && !slot_text;
        result.left_duty      = run_next ? duty_left(steer_next)  : 8'd0;
        result.right_duty     = run_next ? duty_right(steer_next) : 8'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg  <= 24'd0;
            steer_reg   <= 8'd0;
            text0_reg   <= 8'd0;
            mode_reg    <= 8'd0;
            station_reg <= 8'd0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                station_reg <= cfg_data;
            end
            if (in_fire)
            begin
                window_reg <= {window_reg[15:0], s_tdata};
                steer_reg  <= steer_next;
                text0_reg  <= text0_next;
                mode_reg   <= mode_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= in_fire;
            end
        end
        else if (in_fire)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || m_tready)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (in_fire)
            begin
                out_reg <= result;
            end
        end
        else if (in_fire)
        begin
            skid_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_reg.right_duty, out_reg.left_duty};
    assign m_tuser  = {out_reg.running, out_reg.slot_rejected, out_reg.frame_accepted};

endmodule
